FILE: design/clsr_pkg.sv
// Package for the combined congruential generator with shuffle table.
// Holds the controller state type and the fixed generator constants.
// No dependencies; every design file imports it.
package clsr_pkg;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WARM,
    S_DRAW,
    S_PUT
  } state_t;

  // First generator constants.
  localparam logic [30:0] MOD_A = 31'd2147483563;
  localparam logic [15:0] MUL_A = 16'd40014;
  localparam logic [15:0] QUO_A = 16'd53668;
  localparam logic [13:0] REM_A = 14'd12211;

  // Second generator constants.
  localparam logic [30:0] MOD_B = 31'd2147483399;
  localparam logic [15:0] MUL_B = 16'd40692;
  localparam logic [15:0] QUO_B = 16'd52774;
  localparam logic [13:0] REM_B = 14'd3791;

  localparam logic [30:0] SECOND_RESET = 31'd123456789;
  localparam logic [30:0] TOP_OUT      = 31'd2147483562;

  // The Schrage quotient z / QUO is estimated as (z * RECIP) >> RECIP_SHIFT.
  // The estimate is exact or one low, and a single compare fixes it.
  localparam int          RECIP_SHIFT = 47;
  localparam logic [31:0] RECIP_A     = 32'((64'd1 << RECIP_SHIFT) / 64'(QUO_A));
  localparam logic [31:0] RECIP_B     = 32'((64'd1 << RECIP_SHIFT) / 64'(QUO_B));

endpackage

FILE: design/clsr_step.sv
// Five-stage Schrage step unit with two lanes, one for each generator.
// Lane 0 computes 40014*z mod 2147483563, lane 1 computes 40692*z mod 2147483399.
// Depends on clsr_pkg for the generator constants.
module clsr_step
  import clsr_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [1:0][30:0] z,
  output logic            done,
  output logic [1:0][30:0] r
);

  logic [4:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], start};
    end
  end

  assign done = vld[4];

  for (genvar g = 0; g < 2; g++) begin : g_lane
    localparam logic [30:0] M  = (g == 0) ? MOD_A : MOD_B;
    localparam logic [15:0] MU = (g == 0) ? MUL_A : MUL_B;
    localparam logic [15:0] Q  = (g == 0) ? QUO_A : QUO_B;
    localparam logic [13:0] RM = (g == 0) ? REM_A : REM_B;
    localparam logic [31:0] RC = (g == 0) ? RECIP_A : RECIP_B;

    logic [62:0] p1;
    logic [30:0] z1;
    logic [15:0] k2;
    logic [16:0] d2;
    logic [15:0] k3;
    logic [15:0] d3;
    logic [31:0] a4;
    logic [29:0] b4;
    logic [30:0] r5;
    logic [31:0] kq;
    logic [31:0] diff;
    logic [32:0] rs;
    logic [32:0] rw;

    assign kq   = 32'(p1[RECIP_SHIFT +: 16]) * 32'(Q);
    assign diff = {1'b0, z1} - kq;

    // The product can go negative by at most k * REM, so one add of the
    // modulus brings it back into range.
    assign rs = {1'b0, a4} - {3'b000, b4};
    assign rw = rs[32] ? (rs + {2'b00, M}) : rs;

    always_ff @(posedge clk) begin
      p1 <= 63'(z[g]) * 63'(RC);
      z1 <= z[g];
      k2 <= p1[RECIP_SHIFT +: 16];
      d2 <= diff[16:0];
      if (d2 >= {1'b0, Q}) begin
        k3 <= k2 + 16'd1;
        d3 <= 16'(d2 - {1'b0, Q});
      end else begin
        k3 <= k2;
        d3 <= d2[15:0];
      end
      a4 <= 32'(d3) * 32'(MU);
      b4 <= 30'(30'(k3) * 30'(RM));
      r5 <= rw[30:0];
    end

    assign r[g] = r5;
  end

endmodule

FILE: design/combined_lcg_shuffle_rng_core.sv
// Top level of the combined congruential generator with a shuffle table.
// Depends on clsr_pkg and on clsr_step for the modular multiply pipeline.
//
//   Channel   Valid      Stall      Payload
//   request   req_valid  req_stall  action, seed_value
//   result    rsp_valid  rsp_stall  deviate
//
// A draw makes one pass through the Schrage step pipeline, then hands its result to
// the output register, or to the holding register while the output is stalled.
// A reseed adds TABLE_DEPTH + 8 warm-up steps, one pipeline pass per warm-up step.
// Reset sets the generators to 1 and 123456789; the table reads as zero through
// per-entry valid bits, so there is no clearing pass.
// A result stalled at the output waits in a holding register; req_stall is high
// while a request is in work or its result is held.
module combined_lcg_shuffle_rng_core
  import clsr_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        action,
  input  logic [30:0] seed_value,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [30:0] deviate
);

  localparam int AW        = $clog2(TABLE_DEPTH);
  localparam int WCW       = $clog2(TABLE_DEPTH + 8);
  localparam int IW        = AW + 2;
  localparam int IDX_SHIFT = 40;

  localparam logic [31:0]    BIN        = 32'd1 + 32'(TOP_OUT) / 32'(TABLE_DEPTH);
  localparam logic [17:0]    BIN_RECIP  = 18'((64'd1 << IDX_SHIFT) / 64'(BIN));
  localparam logic [WCW-1:0] WARM_START = WCW'(TABLE_DEPTH + 7);
  localparam logic [IW-1:0]  LAST_IDX   = IW'(TABLE_DEPTH - 1);

  state_t state;
  state_t state_next;

  logic [30:0]    first_gen;
  logic [30:0]    second_gen;
  logic [30:0]    last_out;
  logic [30:0]    y_hold;
  logic [WCW-1:0] warm_j;

  logic [30:0]            tab_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tab_vld;
  logic [30:0]            rd_data;
  logic                   rd_vld;

  logic [48:0]   ip;
  logic [30:0]   ilo;
  logic [IW-1:0] iest;
  logic [31:0]   idiff;
  logic [AW-1:0] idx_r;
  logic [IW-1:0] idx_inc;
  logic [IW-1:0] idx_sat;

  logic            accept;
  logic            out_free;
  logic            launch;
  logic            draw_launch;
  logic            load_out;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [1:0][30:0] step_z;
  logic [1:0][30:0] step_r;
  logic            step_done;
  logic [30:0]     lo_src;
  logic [30:0]     seed1;
  logic            warm_write;
  logic            warm_last;
  logic [30:0]     entry;
  logic [32:0]     ydiff;
  logic [32:0]     yadj;
  logic [30:0]     y;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign seed1     = (seed_value == '0) ? 31'd1 : seed_value;

  assign warm_write = (32'(warm_j) < 32'(TABLE_DEPTH));
  assign warm_last  = (warm_j == '0);

  // New deviate: picked entry minus the second generator, wrapped into 1..TOP_OUT.
  assign entry = rd_vld ? rd_data : '0;
  assign ydiff = {2'b00, entry} - {2'b00, step_r[1]};
  assign yadj  = (ydiff[32] || (ydiff == '0)) ? (ydiff + {2'b00, TOP_OUT}) : ydiff;
  assign y     = yadj[30:0];

  clsr_step u_step (
    .clk   (clk),
    .rst   (rst),
    .start (launch),
    .z     (step_z),
    .done  (step_done),
    .r     (step_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    launch      = 1'b0;
    draw_launch = 1'b0;
    load_out    = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = idx_r;
    step_z[0]   = first_gen;
    step_z[1]   = second_gen;
    lo_src      = last_out;
    case (state)
      S_IDLE: begin
        if (accept) begin
          launch = 1'b1;
          if (action) begin
            step_z[0]  = seed1;
            state_next = S_WARM;
          end else begin
            draw_launch = 1'b1;
            state_next  = S_DRAW;
          end
        end
      end
      S_WARM: begin
        if (step_done) begin
          wr_en     = warm_write;
          wr_addr   = warm_j[AW-1:0];
          launch    = 1'b1;
          step_z[0] = step_r[0];
          // The last warm-up value is entry zero and also picks the first slot.
          if (warm_last) begin
            draw_launch = 1'b1;
            lo_src      = step_r[0];
            state_next  = S_DRAW;
          end
        end
      end
      S_DRAW: begin
        if (step_done) begin
          wr_en      = 1'b1;
          load_out   = out_free;
          state_next = out_free ? S_IDLE : S_PUT;
        end
      end
      S_PUT: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_gen  <= 31'd1;
      second_gen <= SECOND_RESET;
      last_out   <= '0;
      warm_j     <= '0;
      tab_vld    <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (accept && action) begin
        first_gen  <= seed1;
        second_gen <= seed1;
        warm_j     <= WARM_START;
      end
      if (step_done && (state == S_WARM)) begin
        first_gen <= step_r[0];
        warm_j    <= warm_j - WCW'(1);
        if (warm_last) begin
          last_out <= step_r[0];
        end
      end
      if (step_done && (state == S_DRAW)) begin
        first_gen  <= step_r[0];
        second_gen <= step_r[1];
        last_out   <= y;
      end
      if (wr_en) begin
        tab_vld[wr_addr] <= 1'b1;
      end
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Slot index: last_out / BIN by reciprocal multiply, then one correction.
  assign idx_inc = iest + IW'(idiff >= BIN);
  assign idx_sat = (idx_inc > LAST_IDX) ? LAST_IDX : idx_inc;

  always_ff @(posedge clk) begin
    if (draw_launch) begin
      ip  <= 49'(lo_src) * 49'(BIN_RECIP);
      ilo <= lo_src;
    end
    iest  <= ip[IDX_SHIFT +: IW];
    idiff <= {1'b0, ilo} - 32'(32'(ip[IDX_SHIFT +: IW]) * BIN);
    idx_r <= idx_sat[AW-1:0];
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tab_mem[wr_addr] <= step_r[0];
    end
    rd_data <= tab_mem[idx_r];
    rd_vld  <= tab_vld[idx_r];
  end

  always_ff @(posedge clk) begin
    if (step_done && (state == S_DRAW)) begin
      y_hold <= y;
    end
    if (load_out) begin
      deviate <= (state == S_PUT) ? y_hold : y;
    end
  end

  a_done_in_work: assert property (@(posedge clk) disable iff (rst)
    step_done |-> (state == S_WARM || state == S_DRAW))
    else $error("step result arrived with no step in work");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (step_done && state == S_DRAW) |-> (32'(idx_r) < 32'(TABLE_DEPTH)))
    else $error("shuffle slot out of range");

  a_gen_range: assert property (@(posedge clk) disable iff (rst)
    (step_done && state == S_DRAW) |=> (first_gen < MOD_A && second_gen < MOD_B))
    else $error("generator left its residue range");

  a_dev_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (deviate != '0 && deviate <= TOP_OUT))
    else $error("deviate outside 1..TOP_OUT");

endmodule
